// ===== rtl/i2c_master_byte_sequencer_top_assert.svh =====
// Assertion macros for the byte sequencer.
// Both sample on clk and are disabled while arst_n is low.
`ifndef I2C_MASTER_BYTE_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_BYTE_SEQUENCER_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define I2CMBS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cmbs same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define I2CMBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cmbs next-cycle check failed");

`endif

// ===== rtl/i2cmbs_pkg.sv =====
package i2cmbs_pkg;

	// Data bytes per transfer are clamped to this
	localparam int unsigned MAX_BYTES = 256;

	localparam int unsigned LEN_W = 9;
	localparam int unsigned IDX_W = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_SLAVE_ADDRESS    = 3'd0;
	localparam logic [IDX_W-1:0] REG_READ_DIRECTION   = 3'd1;
	localparam logic [IDX_W-1:0] REG_TRANSFER_LENGTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_HOLD_FOR_RESTART = 3'd3;
	localparam logic [IDX_W-1:0] REG_PROBE_ONLY       = 3'd4;

	// Line actions
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	// Shift counts
	localparam logic [3:0] BITS_NONE = 4'd0;
	localparam logic [3:0] BITS_ONE  = 4'd1;
	localparam logic [3:0] BITS_BYTE = 4'd8;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	typedef enum logic [7:0] {
		PH_START      = 8'b0000_0001,
		PH_ADDR_ACK   = 8'b0000_0010,
		PH_ADDR_CHECK = 8'b0000_0100,
		PH_SEND_ACK   = 8'b0000_1000,
		PH_PREP_STOP  = 8'b0001_0000,
		PH_DATA_ACK   = 8'b0010_0000,
		PH_DATA_CHECK = 8'b0100_0000,
		PH_STOP       = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0]       slave_address;
		logic             read_direction;
		logic [LEN_W-1:0] transfer_length;
		logic             hold_for_restart;
		logic             probe_only;
	} cfg_t;

	typedef struct packed {
		logic [7:0] shift_load;
		logic [3:0] shift_bits;
		logic       sda_drive;
		logic [1:0] line_action;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       tx_taken;
		logic       present_flag;
		logic       transfer_done;
	} result_t;

endpackage

// ===== rtl/i2cmbs_ifs.sv =====
interface i2cmbs_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] shift_in;
	logic [7:0] tx_byte;

	modport source (output valid, output shift_in, output tx_byte, input ready);
	modport sink   (input valid, input shift_in, input tx_byte, output ready);
endinterface

interface i2cmbs_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] shift_load;
	logic [3:0] shift_bits;
	logic       sda_drive;
	logic [1:0] line_action;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic       tx_taken;
	logic       present_flag;
	logic       transfer_done;

	modport source (output valid, output shift_load, output shift_bits, output sda_drive,
		output line_action, output rx_byte, output rx_valid, output tx_taken,
		output present_flag, output transfer_done, input ready);
	modport sink (input valid, input shift_load, input shift_bits, input sda_drive,
		input line_action, input rx_byte, input rx_valid, input tx_taken,
		input present_flag, input transfer_done, output ready);
endinterface

interface i2cmbs_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [8:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/i2cmbs_seq.sv =====
module i2cmbs_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  i2cmbs_pkg::cfg_t   cfg,
	input  logic [7:0]         shift_in,
	input  logic [7:0]         tx_byte,
	output i2cmbs_pkg::result_t res
);
	import i2cmbs_pkg::*;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;
	logic             seen_q, seen_d;
	logic [LEN_W-1:0] len;
	logic             nack;

	// effective length: zero acts as one, clamp at MAX_BYTES
	always_comb begin
		len = cfg.transfer_length;
		if (len == '0)
			len = LEN_W'(1);
		if ({{(32-LEN_W){1'b0}}, len} > 32'(MAX_BYTES))
			len = LEN_W'(MAX_BYTES);
	end

	assign nack = shift_in[0];

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		seen_d  = seen_q;
		res = '0;
		res.shift_load  = shift_in;
		res.shift_bits  = BITS_NONE;
		res.line_action = ACT_NONE;
		unique case (phase_q)
			PH_START: begin
				cnt_d  = '0;
				seen_d = 1'b0;
				res.line_action = ACT_START;
				res.shift_load  = {cfg.slave_address[7:1], cfg.read_direction};
				res.shift_bits  = BITS_BYTE;
				res.sda_drive   = 1'b1;
				phase_d = PH_ADDR_ACK;
			end
			PH_ADDR_ACK: begin
				res.shift_bits = BITS_ONE;
				phase_d = PH_ADDR_CHECK;
			end
			PH_ADDR_CHECK: begin
				if (!cfg.read_direction) begin
					res.sda_drive = 1'b1;
					if (nack || cfg.probe_only) begin
						seen_d = !nack;
						res.shift_load = BYTE_ZERO;
						res.shift_bits = BITS_ONE;
						phase_d = PH_STOP;
					end else begin
						seen_d = 1'b1;
						res.shift_load = tx_byte;
						res.shift_bits = BITS_BYTE;
						res.tx_taken   = 1'b1;
						cnt_d   = cnt_q + LEN_W'(1);
						phase_d = PH_DATA_ACK;
					end
				end else if (nack) begin
					res.sda_drive  = 1'b1;
					res.shift_load = BYTE_ZERO;
					res.shift_bits = BITS_ONE;
					phase_d = PH_PREP_STOP;
				end else begin
					seen_d = 1'b1;
					res.shift_bits = BITS_BYTE;
					phase_d = PH_SEND_ACK;
				end
			end
			PH_SEND_ACK: begin
				res.sda_drive  = 1'b1;
				res.shift_bits = BITS_ONE;
				res.rx_byte    = shift_in;
				res.rx_valid   = 1'b1;
				// more bytes to come: ack, else nack the last one
				if ({1'b0, cnt_q} + (LEN_W+1)'(2) <= {1'b0, len}) begin
					res.shift_load = BYTE_ZERO;
					cnt_d   = cnt_q + LEN_W'(1);
					phase_d = PH_ADDR_CHECK;
				end else begin
					res.shift_load = BYTE_ONES;
					phase_d = PH_PREP_STOP;
				end
			end
			PH_PREP_STOP: begin
				res.sda_drive  = 1'b1;
				res.shift_load = BYTE_ZERO;
				res.shift_bits = BITS_ONE;
				phase_d = PH_STOP;
			end
			PH_DATA_ACK: begin
				res.shift_bits = BITS_ONE;
				phase_d = PH_DATA_CHECK;
			end
			PH_DATA_CHECK: begin
				res.sda_drive = 1'b1;
				if (cnt_q >= len) begin
					// SDA held high for a repeated start: no stop forms
					res.shift_load = cfg.hold_for_restart ? BYTE_ONES : BYTE_ZERO;
					res.shift_bits = BITS_ONE;
					phase_d = PH_STOP;
				end else begin
					res.shift_load = tx_byte;
					res.shift_bits = BITS_BYTE;
					res.tx_taken   = 1'b1;
					cnt_d   = cnt_q + LEN_W'(1);
					phase_d = PH_DATA_ACK;
				end
			end
			PH_STOP: begin
				res.shift_load    = BYTE_ONES;
				res.line_action   = ACT_STOP;
				res.transfer_done = 1'b1;
				phase_d = PH_START;
			end
			default: begin
				phase_d = PH_START;
			end
		endcase
		res.present_flag = seen_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			seen_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			seen_q  <= seen_d;
		end
	end

endmodule

// ===== rtl/i2c_master_byte_sequencer_top.sv =====
// Channel   Dir   Handshake      Payload
// item      in    valid/ready    shift_in, tx_byte (one shift-complete event)
// result    out   valid/ready    shift_load .. transfer_done (one per item)
// cfg       in    valid/ready    index (3 bits), data (9 bits); ready tied high
//
// Each accepted item passes the item register (_s1) and then the result register;
// one item per cycle sustained while the result is taken. The rate is set by the
// phase/counter update in the sequencer, which sits between those two registers.
// A stalled result holds in its register; the item stage still takes a request
// if it is empty, then ready drops until the result drains.
// arst_n clears both valid flags, puts the phase back to start and the config at reset values.
`include "i2c_master_byte_sequencer_top_assert.svh"

module i2c_master_byte_sequencer_top (
	input  logic             clk,
	input  logic             arst_n,
	i2cmbs_item_if.sink      item,
	i2cmbs_result_if.source  result,
	i2cmbs_cfg_if.sink       cfg
);
	import i2cmbs_pkg::*;

	cfg_t       cfg_q;
	logic       item_valid_s1;
	logic [7:0] shift_in_s1;
	logic [7:0] tx_byte_s1;
	logic       res_valid_q;
	result_t    res_q;
	result_t    res_d;
	logic       step;

	// ---- configuration registers; writes must only arrive while idle: a user rule, unchecked here ----
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address    <= '0;
			cfg_q.read_direction   <= 1'b0;
			cfg_q.transfer_length  <= LEN_W'(1);
			cfg_q.hold_for_restart <= 1'b0;
			cfg_q.probe_only       <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SLAVE_ADDRESS:    cfg_q.slave_address    <= cfg.data[7:0];
				REG_READ_DIRECTION:   cfg_q.read_direction   <= cfg.data[0];
				REG_TRANSFER_LENGTH:  cfg_q.transfer_length  <= cfg.data;
				REG_HOLD_FOR_RESTART: cfg_q.hold_for_restart <= cfg.data[0];
				REG_PROBE_ONLY:       cfg_q.probe_only       <= cfg.data[0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// ---- pipeline control ----
	// step: the item in s1 is processed and its result moves to the output reg
	assign step       = item_valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !item_valid_s1 || step;

	// item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_valid_s1 <= 1'b0;
		else if (item.ready)
			item_valid_s1 <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			shift_in_s1 <= item.shift_in;
			tx_byte_s1  <= item.tx_byte;
		end
	end

	// ---- phase sequencer ----
	i2cmbs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cfg      (cfg_q),
		.shift_in (shift_in_s1),
		.tx_byte  (tx_byte_s1),
		.res      (res_d)
	);

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (step)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res_d;
	end

	assign result.valid         = res_valid_q;
	assign result.shift_load    = res_q.shift_load;
	assign result.shift_bits    = res_q.shift_bits;
	assign result.sda_drive     = res_q.sda_drive;
	assign result.line_action   = res_q.line_action;
	assign result.rx_byte       = res_q.rx_byte;
	assign result.rx_valid      = res_q.rx_valid;
	assign result.tx_taken      = res_q.tx_taken;
	assign result.present_flag  = res_q.present_flag;
	assign result.transfer_done = res_q.transfer_done;

	// ---- checks ----
	// a full item stage behind a stalled result must not take another request
	`I2CMBS_ASSERT_SAME(a_stall_blocks_item, item_valid_s1 && res_valid_q && !result.ready, !item.ready)
	// every processed item shows up as a result in the next cycle
	`I2CMBS_ASSERT_NEXT(a_step_gives_result, step, result.valid)
	// a received byte is never reported together with a buffer advance, and always with SDA driven
	`I2CMBS_ASSERT_SAME(a_rx_not_tx, res_valid_q && res_q.rx_valid, !res_q.tx_taken && res_q.sda_drive)

endmodule

// ===== tb/i2c_master_byte_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

// Byte sequencer bench: shift-complete events go in through the item channel, one result
// comes back per event. Each accepted event runs through a local model of the phase
// machine, and the result it gives is queued. Results are then checked in order.
module i2c_master_byte_sequencer_top_tb;
	import i2cmbs_pkg::*;

	localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, long enough to fill the pipe
	localparam int unsigned QUIET_LIMIT  = 4000;  // cycles without any handshake before giving up
	localparam int unsigned DRAIN_CYCLES = 8;     // settling margin before the run ends

	typedef struct packed {
		logic [7:0] shift_in;
		logic [7:0] tx_byte;
	} shift_event_t;

	logic clk;
	logic arst_n;

	i2cmbs_item_if   item_ch ();
	i2cmbs_result_if res_ch ();
	i2cmbs_cfg_if    cfg_ch ();

	i2c_master_byte_sequencer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// ---------------------------------------------------------------------------------
	// Local copy of the configuration and of the sequencer state, at reset values
	// ---------------------------------------------------------------------------------
	logic [7:0]       reg_address    = 8'h00;
	logic             reg_read       = 1'b0;
	logic [LEN_W-1:0] reg_length     = 9'd1;
	logic             reg_hold       = 1'b0;
	logic             reg_probe      = 1'b0;
	phase_t           seq_phase      = PH_START;
	int unsigned      bytes_done     = 0;
	logic             slave_ack_seen = 1'b0;

	shift_event_t pending_events[$];   // stimulus not yet offered
	result_t      predicted_steps[$];  // results owed by the block, oldest first

	int unsigned mismatches    = 0;
	int unsigned quiet_cycles  = 0;
	bit          event_taken   = 1'b0;  // item handshake at the last rising edge
	bit          result_taken  = 1'b0;  // result handshake at the last rising edge
	bit          sender_idles  = 1'b0;
	bit          receiver_idles = 1'b0;
	int unsigned send_gap      = 0;
	int unsigned recv_gap      = 0;
	int unsigned hold_left     = 0;
	int unsigned hold_requests = 0;     // bumped by the sequence, served by the receiver
	int unsigned holds_served  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, some short ones, the odd long one
	function automatic int unsigned pick_gap(input bit idles);
		int unsigned roll;
		if (!idles)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_mirror(input logic [IDX_W-1:0] idx, input logic [8:0] value);
		case (idx)
			REG_SLAVE_ADDRESS:    reg_address = value[7:0];
			REG_READ_DIRECTION:   reg_read    = value[0];
			REG_TRANSFER_LENGTH:  reg_length  = value;
			REG_HOLD_FOR_RESTART: reg_hold    = value[0];
			REG_PROBE_ONLY:       reg_probe   = value[0];
			default: ;
		endcase
	endtask

	// One shift-complete event through the phase machine
	task automatic sequence_event(input logic [7:0] sin, input logic [7:0] txb,
			output result_t r);
		logic        nack;
		int unsigned len;
		nack = sin[0];
		// zero length acts as one, oversize is clamped
		len = (reg_length == 0) ? 1 : reg_length;
		if (len > MAX_BYTES)
			len = MAX_BYTES;
		r = '0;
		r.shift_load  = sin;
		r.shift_bits  = BITS_NONE;
		r.line_action = ACT_NONE;
		case (seq_phase)
			PH_START: begin
				bytes_done     = 0;
				slave_ack_seen = 1'b0;
				r.line_action  = ACT_START;
				// address LSB is replaced by the direction bit
				r.shift_load   = {reg_address[7:1], reg_read};
				r.shift_bits   = BITS_BYTE;
				r.sda_drive    = 1'b1;
				seq_phase      = PH_ADDR_ACK;
			end
			PH_ADDR_ACK: begin
				r.shift_bits = BITS_ONE;
				seq_phase    = PH_ADDR_CHECK;
			end
			PH_ADDR_CHECK: begin
				if (!reg_read) begin
					r.sda_drive = 1'b1;
					if (nack || reg_probe) begin
						// probe ends here; a nack also clears presence
						slave_ack_seen = !nack;
						r.shift_load   = BYTE_ZERO;
						r.shift_bits   = BITS_ONE;
						seq_phase      = PH_STOP;
					end else begin
						slave_ack_seen = 1'b1;
						r.shift_load   = txb;
						r.shift_bits   = BITS_BYTE;
						r.tx_taken     = 1'b1;
						bytes_done++;
						seq_phase      = PH_DATA_ACK;
					end
				end else if (nack) begin
					// read mode: probe ignored, presence left as it was
					r.sda_drive  = 1'b1;
					r.shift_load = BYTE_ZERO;
					r.shift_bits = BITS_ONE;
					seq_phase    = PH_PREP_STOP;
				end else begin
					slave_ack_seen = 1'b1;
					r.shift_bits   = BITS_BYTE;
					seq_phase      = PH_SEND_ACK;
				end
			end
			PH_SEND_ACK: begin
				r.sda_drive  = 1'b1;
				r.shift_bits = BITS_ONE;
				r.rx_byte    = sin;
				r.rx_valid   = 1'b1;
				if (bytes_done + 2 <= len) begin
					r.shift_load = BYTE_ZERO;  // ACK, more to come
					bytes_done++;
					seq_phase    = PH_ADDR_CHECK;
				end else begin
					r.shift_load = BYTE_ONES;  // NACK on the last byte
					seq_phase    = PH_PREP_STOP;
				end
			end
			PH_PREP_STOP: begin
				r.sda_drive  = 1'b1;
				r.shift_load = BYTE_ZERO;
				r.shift_bits = BITS_ONE;
				seq_phase    = PH_STOP;
			end
			PH_DATA_ACK: begin
				r.shift_bits = BITS_ONE;
				seq_phase    = PH_DATA_CHECK;
			end
			PH_DATA_CHECK: begin
				// a data nack changes nothing here
				r.sda_drive = 1'b1;
				if (bytes_done >= len) begin
					r.shift_load = reg_hold ? BYTE_ONES : BYTE_ZERO;
					r.shift_bits = BITS_ONE;
					seq_phase    = PH_STOP;
				end else begin
					r.shift_load = txb;
					r.shift_bits = BITS_BYTE;
					r.tx_taken   = 1'b1;
					bytes_done++;
					seq_phase    = PH_DATA_ACK;
				end
			end
			default: begin
				// stop: held SDA high on repeated-start hold, so no stop forms
				r.shift_load    = BYTE_ONES;
				r.line_action   = ACT_STOP;
				r.transfer_done = 1'b1;
				seq_phase       = PH_START;
			end
		endcase
		r.present_flag = slave_ack_seen;
	endtask

	task automatic compare_field(input string name, input logic [8:0] want,
			input logic [8:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Driver: offers the queued events, holds each until taken, then maybe idles
	// ---------------------------------------------------------------------------------
	always @(negedge clk) begin
		shift_event_t ev;
		if (arst_n && (!item_ch.valid || event_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				item_ch.valid <= 1'b0;
			end else if (pending_events.size() != 0) begin
				ev = pending_events.pop_front();
				item_ch.valid    <= 1'b1;
				item_ch.shift_in <= ev.shift_in;
				item_ch.tx_byte  <= ev.tx_byte;
				send_gap = pick_gap(sender_idles);
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold-off whenever one is asked for
	always @(negedge clk) begin
		if (arst_n) begin
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left    = LONG_HOLD;
			end
			if (result_taken)
				recv_gap = pick_gap(receiver_idles);
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Monitor: mirrors register writes, predicts on each accepted event, checks results
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		result_t predicted;
		if (arst_n) begin
			event_taken  = item_ch.valid && item_ch.ready;
			result_taken = res_ch.valid && res_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready)
				write_mirror(cfg_ch.index, cfg_ch.data);
			if (event_taken) begin
				sequence_event(item_ch.shift_in, item_ch.tx_byte, predicted);
				predicted_steps.push_back(predicted);
			end
			if (result_taken) begin
				if (predicted_steps.size() == 0) begin
					$error("result with nothing predicted: shift_load %0h", res_ch.shift_load);
					mismatches++;
				end else begin
					predicted = predicted_steps.pop_front();
					compare_field("shift_load", predicted.shift_load, res_ch.shift_load);
					compare_field("shift_bits", predicted.shift_bits, res_ch.shift_bits);
					compare_field("sda_drive", predicted.sda_drive, res_ch.sda_drive);
					compare_field("line_action", predicted.line_action, res_ch.line_action);
					compare_field("rx_byte", predicted.rx_byte, res_ch.rx_byte);
					compare_field("rx_valid", predicted.rx_valid, res_ch.rx_valid);
					compare_field("tx_taken", predicted.tx_taken, res_ch.tx_taken);
					compare_field("present_flag", predicted.present_flag, res_ch.present_flag);
					compare_field("transfer_done", predicted.transfer_done,
						res_ch.transfer_done);
				end
			end
		end
	end

	// Watchdog: any handshake counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Sequence helpers
	// ---------------------------------------------------------------------------------
	task automatic push_event(input logic [7:0] sin, input logic [7:0] txb);
		pending_events.push_back('{shift_in: sin, tx_byte: txb});
	endtask

	// Random content; nack_pct biases the ack bit so transfers get past the address
	task automatic queue_events(input int unsigned count, input int unsigned nack_pct);
		logic [7:0] sin;
		for (int unsigned i = 0; i < count; i++) begin
			sin    = 8'($urandom);
			sin[0] = ($urandom_range(0, 99) < nack_pct);
			push_event(sin, 8'($urandom));
		end
	endtask

	// Sender paused: returns once every owed result has come back
	task automatic wait_idle();
		@(negedge clk);
		while (pending_events.size() != 0 || item_ch.valid || predicted_steps.size() != 0)
			@(negedge clk);
	endtask

	// Leaves valid high between back-to-back writes; configure() drops it at the end
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [8:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	// Writes all five registers; unused data bits carry junk, which must be ignored
	task automatic configure(input logic [7:0] addr, input logic rd, input logic [8:0] len,
			input logic hold, input logic probe);
		write_reg(REG_SLAVE_ADDRESS, {1'($urandom), addr});
		write_reg(REG_READ_DIRECTION, {8'($urandom), rd});
		write_reg(REG_TRANSFER_LENGTH, len);
		write_reg(REG_HOLD_FOR_RESTART, {8'($urandom), hold});
		write_reg(REG_PROBE_ONLY, {8'($urandom), probe});
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------
	initial begin
		logic [8:0]  len;
		int unsigned nack_pct;
		int unsigned roll;

		item_ch.valid    = 1'b0;
		item_ch.shift_in = 8'h00;
		item_ch.tx_byte  = 8'h00;
		res_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_SLAVE_ADDRESS;
		cfg_ch.data      = 9'd0;
		arst_n           = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: zero length acting as one, repeated-start hold, address LSB overwritten
		configure(8'hFF, 1'b0, 9'd0, 1'b1, 1'b0);
		push_event(8'h00, 8'hFF);  // start + address
		push_event(8'hFF, 8'h00);  // address ack bit
		push_event(8'hFE, 8'hFF);  // ack, first byte loaded
		push_event(8'h00, 8'h00);
		push_event(8'h01, 8'h5A);  // data nack, count reached anyway
		push_event(8'hFF, 8'hFF);  // stop with SDA held
		wait_idle();

		// Probe: address nack clears presence; probe stays set for the next transfer
		configure(8'h00, 1'b0, 9'd2, 1'b0, 1'b1);
		push_event(8'h00, 8'h00);
		push_event(8'h00, 8'h00);
		push_event(8'h01, 8'hA5);
		push_event(8'h00, 8'h00);
		push_event(8'hFF, 8'h3C);
		push_event(8'hFF, 8'hC3);
		push_event(8'h00, 8'hFF);  // ack, probe stops it
		push_event(8'h00, 8'h00);
		wait_idle();

		// Read of two bytes with probe still set (ignored when reading)
		write_reg(REG_READ_DIRECTION, 9'd1);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		push_event(8'h00, 8'h00);
		push_event(8'h00, 8'h00);
		push_event(8'h00, 8'h00);  // address ack
		push_event(8'hA5, 8'hFF);  // first byte in, ACK
		push_event(8'h00, 8'h00);
		push_event(8'h5A, 8'h00);  // last byte in, NACK
		push_event(8'hFF, 8'hFF);
		push_event(8'h00, 8'h00);
		wait_idle();

		// Oversize write length clamped to the maximum, with a long receiver hold-off
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		configure(8'($urandom), 1'b0, 9'd511, 1'b0, 1'b0);
		hold_requests++;
		queue_events(520, 0);
		wait_idle();

		// Longest read, no idling on either side
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		configure(8'($urandom), 1'b1, 9'(MAX_BYTES), 1'($urandom), 1'($urandom));
		queue_events(520, 0);
		wait_idle();

		// Mostly short transfers, some clamped oversize ones, random settings, nacks in the mix
		for (int p = 0; p < 10; p++) begin
			roll = $urandom_range(0, 9);
			if (roll < 7)
				len = 9'($urandom_range(0, 6));
			else if (roll < 9)
				len = 9'($urandom_range(7, 24));
			else
				len = 9'($urandom_range(257, 511));
			case ($urandom_range(0, 2))
				0:       nack_pct = 0;
				1:       nack_pct = 10;
				default: nack_pct = 30;
			endcase
			sender_idles   = p[0];
			receiver_idles = 1'($urandom);
			configure(8'($urandom), 1'($urandom), len, 1'($urandom), 1'($urandom));
			if (p == 5)
				hold_requests++;
			queue_events(40, nack_pct);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2cmbs_pkg.sv
rtl/i2cmbs_ifs.sv
rtl/i2cmbs_seq.sv
rtl/i2c_master_byte_sequencer_top.sv
tb/i2c_master_byte_sequencer_top_tb.sv
